>>> hw/rtl/steq_pkg.sv
// ----------------------------------------------------------------------------
// steq_pkg
// Shared types and constants for the sorted timer expiry queue.
// ----------------------------------------------------------------------------
package steq_pkg;

    localparam int ID_W         = 31;
    localparam int TIME_W       = 63;
    localparam int RESULT_LIMIT = 16;
    localparam int NUM_W        = 5;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_INSERT  = 1'b1;
    localparam logic KIND_FIRED  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ID_W-1:0]   timer_tag;
        logic [TIME_W-1:0] due_time;
        logic [TIME_W-1:0] now_time;
    } request_t;

    typedef struct packed {
        logic              result_kind;
        logic [ID_W-1:0]   fired_id;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] fire_time;
        logic [TIME_W-1:0] slippage;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] deadline;
    } entry_t;

endpackage

>>> hw/rtl/sorted_timer_expiry_queue.sv
// ----------------------------------------------------------------------------
// sorted_timer_expiry_queue
// Deadline-sorted timer store in a circular RAM, driven by a small sequencer
// around one shared 63-bit subtractor.
// ----------------------------------------------------------------------------
// tick: T_RD, T_CMP per fired timer; ends in T_RD (empty or limit) or T_CMP (not due)
// a tick result is held until the next one fires or the tick ends (then marked last)
// insert fired at once or rejected: busy in the due check, strobe in the next cycle
// insert stored: due check, read/compare per later entry, then final read or compare
// one RAM read port and one shared subtractor set these steps; results cannot be stalled
// reset empties the store (count and head cleared); RAM contents are kept
module sorted_timer_expiry_queue #(
    parameter int STORE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  steq_pkg::request_t request,
    output logic               result_strobe,
    output steq_pkg::result_t  result
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_T_RD  = 3'd1;
    localparam logic [2:0] ST_T_CMP = 3'd2;
    localparam logic [2:0] ST_I_DUE = 3'd3;
    localparam logic [2:0] ST_I_RD  = 3'd4;
    localparam logic [2:0] ST_I_CMP = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [AW-1:0]                  head_reg, head_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  pos_reg, pos_next;
    logic [steq_pkg::NUM_W-1:0]     num_reg, num_next;
    logic                           have_pend_reg, have_pend_next;
    logic                           out_valid_reg, out_valid_next;
    steq_pkg::result_t              out_reg, out_next;
    steq_pkg::result_t              pend_reg, pend_next;
    steq_pkg::request_t             req_reg, req_next;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [AW-1:0]                  ram_raddr;
    steq_pkg::entry_t               ram_wdata;
    steq_pkg::entry_t               ram_rdata;

    logic [steq_pkg::TIME_W-1:0]    sub_a, sub_b, sub_diff;
    logic                           sub_borrow;
    steq_pkg::entry_t               new_entry;

    // circular index, base plus offset with one wrap
    function automatic logic [AW-1:0] wrap_idx(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(STORE_DEPTH))
        begin
            s = s - SW'(STORE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    steq_ram #(
        .WIDTH ($bits(steq_pkg::entry_t)),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    steq_sub u_sub (
        .a      (sub_a),
        .b      (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    assign sub_a = (state_reg == ST_I_CMP) ? req_reg.due_time : req_reg.now_time;
    assign sub_b = (state_reg == ST_I_DUE) ? req_reg.due_time : ram_rdata.deadline;

    assign new_entry.id       = req_reg.timer_tag;
    assign new_entry.deadline = req_reg.due_time;

    assign busy          = (state_reg != ST_IDLE);
    assign result_strobe = out_valid_reg;
    assign result        = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        num_next       = num_reg;
        have_pend_next = have_pend_reg;
        out_valid_next = 1'b0;
        out_next       = out_reg;
        pend_next      = pend_reg;
        req_next       = req_reg;
        ram_we         = 1'b0;
        ram_waddr      = wrap_idx(head_reg, pos_reg);
        ram_wdata      = new_entry;
        ram_raddr      = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next       = request;
                    num_next       = '0;
                    have_pend_next = 1'b0;
                    state_next     = (request.command == steq_pkg::CMD_TICK)
                                     ? ST_T_RD : ST_I_DUE;
                end
            end

            ST_T_RD:
            begin
                if (count_reg == '0 ||
                    num_reg == steq_pkg::NUM_W'(steq_pkg::RESULT_LIMIT))
                begin
                    if (have_pend_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                        out_next.last  = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_T_CMP;
                end
            end

            ST_T_CMP:
            begin
                if (!sub_borrow)
                begin
                    // head is due; the held result is not the last one
                    if (have_pend_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                        out_next.last  = 1'b0;
                    end
                    pend_next.result_kind = steq_pkg::KIND_FIRED;
                    pend_next.fired_id    = ram_rdata.id;
                    pend_next.deadline    = ram_rdata.deadline;
                    pend_next.fire_time   = req_reg.now_time;
                    pend_next.slippage    = sub_diff;
                    pend_next.last        = 1'b0;
                    have_pend_next        = 1'b1;
                    head_next  = (head_reg == AW'(STORE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    num_next   = num_reg + 1'b1;
                    state_next = ST_T_RD;
                end
                else
                begin
                    if (have_pend_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                        out_next.last  = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_I_DUE:
            begin
                if (!sub_borrow)
                begin
                    out_valid_next       = 1'b1;
                    out_next.result_kind = steq_pkg::KIND_FIRED;
                    out_next.fired_id    = req_reg.timer_tag;
                    out_next.deadline    = req_reg.due_time;
                    out_next.fire_time   = req_reg.now_time;
                    out_next.slippage    = sub_diff;
                    out_next.last        = 1'b1;
                    state_next           = ST_IDLE;
                end
                else if (count_reg == CW'(STORE_DEPTH))
                begin
                    out_valid_next       = 1'b1;
                    out_next.result_kind = steq_pkg::KIND_REJECT;
                    out_next.fired_id    = req_reg.timer_tag;
                    out_next.deadline    = req_reg.due_time;
                    out_next.fire_time   = '0;
                    out_next.slippage    = '0;
                    out_next.last        = 1'b1;
                    state_next           = ST_IDLE;
                end
                else
                begin
                    pos_next   = count_reg;
                    state_next = ST_I_RD;
                end
            end

            ST_I_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_raddr  = wrap_idx(head_reg, pos_reg - 1'b1);
                    state_next = ST_I_CMP;
                end
            end

            ST_I_CMP:
            begin
                ram_we = 1'b1;
                if (sub_borrow)
                begin
                    // entry is later than the new deadline, move it up one slot
                    ram_wdata  = ram_rdata;
                    pos_next   = pos_reg - 1'b1;
                    state_next = ST_I_RD;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            num_reg       <= '0;
            have_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            num_reg       <= num_next;
            have_pend_reg <= have_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
        req_reg  <= req_next;
    end

endmodule

>>> hw/rtl/steq_ram.sv
// ----------------------------------------------------------------------------
// steq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module steq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/steq_sub.sv
// ----------------------------------------------------------------------------
// steq_sub
// Shared time subtractor: difference and borrow, used for every compare.
// ----------------------------------------------------------------------------
module steq_sub (
    input  logic [steq_pkg::TIME_W-1:0] a,
    input  logic [steq_pkg::TIME_W-1:0] b,
    output logic [steq_pkg::TIME_W-1:0] diff,
    output logic                        borrow
);

    logic [steq_pkg::TIME_W:0] wide;

    // borrow set means a < b
    assign wide   = {1'b0, a} - {1'b0, b};
    assign diff   = wide[steq_pkg::TIME_W-1:0];
    assign borrow = wide[steq_pkg::TIME_W];

endmodule
